### rtl/core/date_diff_pkg.sv
// ----------------------------------------------------------------------------
// date_diff_pkg
// Types, constants and day count functions for the date difference block.
// ----------------------------------------------------------------------------
package date_diff_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 23;
    localparam int ORD_W   = 23;
    localparam int MSTART_W = 9;
    localparam int Q25_W   = 9;

    localparam logic [ORD_W-1:0]   DAYS_PER_YEAR = ORD_W'(365);
    localparam logic [12:0]        DIV25_MUL     = 13'd5243;   // ceil(2^17 / 25)
    localparam int                 DIV25_SHIFT   = 17;
    localparam logic [MONTH_W-1:0] MONTH_LAST_IDX = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_MAR_IDX  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_OVER     = 4'd13;

    localparam logic signed [DIFF_W:0] DIFF_MAX = (DIFF_W+1)'(4194303);
    localparam logic signed [DIFF_W:0] DIFF_MIN = -(DIFF_W+1)'(4194304);

    typedef logic [YEAR_W-1:0]         t_year;
    typedef logic [MONTH_W-1:0]        t_month;
    typedef logic [DAY_W-1:0]          t_day;
    typedef logic [ORD_W-1:0]          t_ordinal;
    typedef logic signed [DIFF_W-1:0]  t_diff;

    typedef struct packed {
        t_year  year;
        t_month month;
        t_day   day;
    } t_date;

    // floor(x / 25), exact for 13-bit x
    function automatic logic [Q25_W-1:0] div25(input logic [12:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'(DIV25_MUL);
        return p[25:DIV25_SHIFT];
    endfunction

    // days before the month in a common year; index 12 is the whole year
    function automatic logic [MSTART_W-1:0] month_start(input t_month idx);
        logic [MSTART_W-1:0] v;
        unique case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            4'd12:   v = 9'd365;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // proleptic Gregorian day count, year zero leap
    function automatic t_ordinal ordinal(input t_date dt);
        logic [14:0]        y3;
        logic [14:0]        y99;
        logic [14:0]        y399;
        logic [12:0]        ceil4;
        logic [Q25_W-1:0]   c100;
        logic [Q25_W-1:0]   f100;
        logic [Q25_W-1:0]   c400;
        logic [Q25_W-1:0]   f400;
        t_month             idx;
        logic               leap;
        t_ordinal           n;
        y3    = {1'b0, dt.year} + 15'd3;
        y99   = {1'b0, dt.year} + 15'd99;
        y399  = {1'b0, dt.year} + 15'd399;
        ceil4 = y3[14:2];
        c100  = div25(y99[14:2]);
        f100  = div25({1'b0, dt.year[13:2]});
        c400  = div25({2'b0, y399[14:4]});
        f400  = div25({3'b0, dt.year[13:4]});
        if (dt.month == '0) begin
            idx = '0;
        end else if (dt.month >= MONTH_OVER) begin
            idx = MONTH_LAST_IDX;
        end else begin
            idx = dt.month - 4'd1;
        end
        leap = ((dt.year[1:0] == 2'b00) && (c100 != f100)) || (c400 == f400);
        n = ORD_W'(dt.year) * DAYS_PER_YEAR
          + ORD_W'(ceil4) - ORD_W'(c100) + ORD_W'(c400)
          + ORD_W'(month_start(idx))
          + ORD_W'(leap && (idx >= MONTH_MAR_IDX))
          + ORD_W'(dt.day);
        return n;
    endfunction

endpackage

### rtl/core/date_difference_in_days.sv
// ----------------------------------------------------------------------------
// date_difference_in_days
// Signed day count from a first to a second Gregorian date.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register, with the day count computed
// combinationally between them. Throughput: one transaction per cycle while
// the receiver does not stall; a receiver stall backs up into o_stall.
// Reset: synchronous, active low; clears both valid flags, payload unreset.
// ----------------------------------------------------------------------------
module date_difference_in_days (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [date_diff_pkg::YEAR_W-1:0]      i_first_year,
    input  logic [date_diff_pkg::MONTH_W-1:0]     i_first_month,
    input  logic [date_diff_pkg::DAY_W-1:0]       i_first_day,
    input  logic [date_diff_pkg::YEAR_W-1:0]      i_second_year,
    input  logic [date_diff_pkg::MONTH_W-1:0]     i_second_month,
    input  logic [date_diff_pkg::DAY_W-1:0]       i_second_day,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [date_diff_pkg::DIFF_W-1:0] o_day_difference
);
    import date_diff_pkg::*;

    logic      r_in_valid;
    t_date     r_first;
    t_date     r_second;
    logic      r_out_valid;
    t_diff     r_diff;
    t_diff     n_diff;

    logic      out_ready;
    logic      in_ready;
    t_ordinal  ord_first;
    t_ordinal  ord_second;
    logic signed [DIFF_W:0] raw_diff;

    assign out_ready = !r_out_valid || !i_stall;
    assign in_ready  = !r_in_valid || out_ready;
    assign o_stall   = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_first  <= '{year: i_first_year, month: i_first_month, day: i_first_day};
            r_second <= '{year: i_second_year, month: i_second_month, day: i_second_day};
        end
    end

    always_comb begin
        ord_first  = ordinal(r_first);
        ord_second = ordinal(r_second);
        raw_diff   = $signed({1'b0, ord_second}) - $signed({1'b0, ord_first});
        if (raw_diff > DIFF_MAX) begin
            n_diff = DIFF_W'(DIFF_MAX);
        end else if (raw_diff < DIFF_MIN) begin
            n_diff = DIFF_W'(DIFF_MIN);
        end else begin
            n_diff = raw_diff[DIFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_diff <= n_diff;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_day_difference = r_diff;

endmodule

### verif/date_difference_in_days_test.sv
// ----------------------------------------------------------------------------
// date_difference_in_days_test
// Self-checking bench for the signed day count between two calendar dates.
// A short directed set hits leap rules, field extremes, unchecked month and
// day values and saturation. A long random set of mostly well-formed dates
// follows. Both handshake sides idle at random, and one long receiver
// hold-off backs the block up into its input. Every result is checked
// against a day count predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module date_difference_in_days_test;

    import date_diff_pkg::*;

    localparam int RANDOM_PAIRS = 1500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 160;
    localparam int HOLD_AT      = 400;

    class day_diff_scoreboard;
        t_diff expected_q[$];
        int    noted;
        int    checked;
        int    saturated;
        int    errors;

        function new();
            noted     = 0;
            checked   = 0;
            saturated = 0;
            errors    = 0;
        endfunction

        function automatic bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // days from the start of year zero up to and including the given day
        function automatic int unsigned day_number(t_date dt);
            int unsigned y;
            int unsigned months_done;
            int unsigned n;
            y = dt.year;
            if (dt.month == 0) begin
                months_done = 0;
            end else if (dt.month > 12) begin
                months_done = 12;
            end else begin
                months_done = dt.month - 1;
            end
            n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
            for (int unsigned k = 0; k < months_done; k++) begin
                if (k == 1) begin
                    n += is_leap(y) ? 29 : 28;
                end else if (k == 3 || k == 5 || k == 8 || k == 10) begin
                    n += 30;
                end else begin
                    n += 31;
                end
            end
            return n + dt.day;
        endfunction

        function automatic t_diff days_between(t_date a, t_date b, output bit clipped);
            longint diff;
            diff = longint'(day_number(b)) - longint'(day_number(a));
            clipped = 1'b0;
            if (diff > longint'(DIFF_MAX)) begin
                diff    = longint'(DIFF_MAX);
                clipped = 1'b1;
            end
            if (diff < longint'(DIFF_MIN)) begin
                diff    = longint'(DIFF_MIN);
                clipped = 1'b1;
            end
            return t_diff'(diff);
        endfunction

        function void note_pair(t_date a, t_date b);
            bit clipped;
            expected_q.push_back(days_between(a, b, clipped));
            noted++;
            if (clipped) begin
                saturated++;
            end
        endfunction

        function void check_difference(t_diff actual);
            t_diff exp_diff;
            if (expected_q.size() == 0) begin
                $error("day_difference: unexpected result %0d, nothing pending", actual);
                errors++;
                return;
            end
            exp_diff = expected_q.pop_front();
            checked++;
            if (actual !== exp_diff) begin
                $error("day_difference mismatch: expected %0d, actual %0d",
                       exp_diff, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic          i_clk          = 1'b0;
    logic          i_rst_n        = 1'b0;
    logic          i_valid        = 1'b0;
    logic          o_stall;
    t_year         i_first_year   = '0;
    t_month        i_first_month  = '0;
    t_day          i_first_day    = '0;
    t_year         i_second_year  = '0;
    t_month        i_second_month = '0;
    t_day          i_second_day   = '0;
    logic          o_valid;
    logic          i_stall        = 1'b0;
    t_diff         o_day_difference;

    day_diff_scoreboard board = new();

    int  cycles      = 0;
    int  burst_left  = 0;
    int  rx_mode     = 0;
    int  rx_mode_left = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    bit  rx_toggle   = 1'b0;

    date_difference_in_days i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_year     (i_first_year),
        .i_first_month    (i_first_month),
        .i_first_day      (i_first_day),
        .i_second_year    (i_second_year),
        .i_second_month   (i_second_month),
        .i_second_day     (i_second_day),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_day_difference (o_day_difference)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, board.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: checks each result transaction and picks its own stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_difference(o_day_difference);
        end
        if (!hold_done && board.noted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 4);
            rx_mode_left = $urandom_range(64, 256);
        end else begin
            rx_mode_left--;
        end
        rx_toggle = !rx_toggle;
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (rx_mode)
                0: begin
                    i_stall <= 1'b0;
                end
                1: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                2: begin
                    i_stall <= ($urandom_range(0, 3) != 0);
                end
                3: begin
                    i_stall <= rx_toggle;
                end
                default: begin
                    i_stall <= (cycles % 4 != 0);
                end
            endcase
        end
    end

    function automatic t_date mk(int y, int m, int d);
        t_date dt;
        dt.year  = t_year'(y);
        dt.month = t_month'(m);
        dt.day   = t_day'(d);
        return dt;
    endfunction

    function automatic int month_days(int m, int y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        if (m == 2) begin
            return leap ? 29 : 28;
        end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic t_date real_date(int y);
        int m;
        m = $urandom_range(1, 12);
        return mk(y, m, $urandom_range(1, month_days(m, y)));
    endfunction

    function automatic void make_pair(output t_date a, output t_date b);
        int    pick;
        int    y;
        t_date tmp;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            a = real_date($urandom_range(1, 9999));
            b = real_date($urandom_range(1, 9999));
        end else if (pick < 72) begin
            case ($urandom_range(0, 2))
                0:       y = $urandom_range(0, 2499) * 4;
                1:       y = $urandom_range(0, 99) * 100;
                default: y = $urandom_range(0, 24) * 400;
            endcase
            a = mk(y, 2, $urandom_range(27, 29));
            b = mk(y + $urandom_range(0, 1), $urandom_range(2, 3), $urandom_range(1, 29));
        end else if (pick < 84) begin
            a = real_date($urandom_range(1, 9999));
            b = a;
            b.day = t_day'($urandom_range(1, month_days(a.month, a.year)));
            if ($urandom_range(0, 1) == 1) begin
                b.month = t_month'($urandom_range(1, 12));
                b.day   = t_day'($urandom_range(1, 28));
            end
        end else if (pick < 90) begin
            a = mk($urandom_range(0, 300), $urandom_range(0, 15), $urandom_range(0, 31));
            b = mk($urandom_range(11000, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
        end else begin
            a = mk($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
            b = mk($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
        end
        if ($urandom_range(0, 1) == 1) begin
            tmp = a;
            a   = b;
            b   = tmp;
        end
    endfunction

    task automatic offer(input t_date a, input t_date b);
        int idle;
        i_first_year   <= a.year;
        i_first_month  <= a.month;
        i_first_day    <= a.day;
        i_second_year  <= b.year;
        i_second_month <= b.month;
        i_second_day   <= b.day;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        board.note_pair(a, b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            idle       = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    initial begin
        t_date a;
        t_date b;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(5, 30);

        offer(mk(2000, 1, 1), mk(2000, 1, 1));
        offer(mk(1, 1, 1), mk(9999, 12, 31));
        offer(mk(9999, 12, 31), mk(1, 1, 1));
        offer(mk(2000, 2, 28), mk(2000, 3, 1));
        offer(mk(1900, 2, 28), mk(1900, 3, 1));
        offer(mk(2024, 2, 29), mk(2023, 3, 1));
        offer(mk(2023, 2, 31), mk(2023, 3, 3));
        offer(mk(2023, 2, 0), mk(2023, 1, 31));
        offer(mk(2023, 0, 5), mk(2023, 1, 5));
        offer(mk(2023, 13, 1), mk(2024, 1, 1));
        offer(mk(2024, 14, 31), mk(2024, 15, 0));
        offer(mk(0, 2, 29), mk(0, 3, 1));
        offer(mk(0, 12, 31), mk(1, 1, 1));
        offer(mk(0, 0, 0), mk(16383, 15, 31));
        offer(mk(16383, 15, 31), mk(0, 0, 0));
        offer(mk(11483, 1, 1), mk(0, 1, 1));
        offer(mk(0, 1, 1), mk(11483, 6, 1));
        offer(mk(1600, 12, 31), mk(2400, 2, 29));
        offer(mk(16383, 1, 31), mk(10922, 15, 16));

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            make_pair(a, b);
            offer(a, b);
        end
        i_valid <= 1'b0;

        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d date pairs, checked %0d differences (%0d clipped to range)",
                 board.noted, board.checked, board.saturated);
        $display("receiver hold-off of %0d cycles exercised: %0d", HOLD_CYCLES, hold_done);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
